>>> sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define CUCT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cuct assertion failed");

// next-cycle implication, disabled while in reset
`define CUCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cuct assertion failed");

`endif

>>> sv/cuct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuct_pkg
// shared types and codes of the channel usage counter table
// ----------------------------------------------------------------------------
package cuct_pkg;

    localparam logic [1:0] ACT_CREATE  = 2'd0;
    localparam logic [1:0] ACT_DESTROY = 2'd1;
    localparam logic [1:0] ACT_UPDATE  = 2'd2;
    localparam logic [1:0] ACT_QUERY   = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_GROUP  = 2'd1;
    localparam logic [1:0] STAT_PAIR_FULL = 2'd2;
    localparam logic [1:0] STAT_PURP_FULL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SWEEP,
        ST_RDCAP,
        ST_SEARCH,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  owner;
        logic [7:0]  remote;
        logic [31:0] tally;
    } pair_entry_t;

    typedef struct packed {
        logic [7:0]  owner;
        logic [7:0]  remote;
        logic [31:0] key;
        logic [7:0]  tally;
    } purp_entry_t;

    // control from the sequencer to one ring
    typedef struct packed {
        logic rotate;
        logic kill;
        logic wr_en;
        logic wr_valid;
    } ring_ctl_t;

    // control from a ring to one of its cells
    typedef struct packed {
        logic shift;
        logic wr_en;
    } cell_ctl_t;

endpackage

>>> sv/channel_usage_counter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_usage_counter_table
// per-domain, per-pair and per-purpose channel usage counters
// ----------------------------------------------------------------------------
// usage: one command word in on the in channel (action, domain, remote_domain,
// purpose, delta), one result word out on the out channel for every command.
// both channels are valid/ready; a word moves when both are high.
// flow: update, query and destroy rotate both tables once, then give their
// result; create of a new group clears its totals, create of an enabled
// group reads its total, and a rejected command goes straight to its result.
// throughput: one command at a time.
// the next command is taken while the previous result still sits in the
// output register; a result waits there while the receiver stalls, and the
// sequencer holds its finished result until that register is free.
// reset: all groups disabled and all table entries invalid; the domain
// totals need no clearing, create zeroes a group before its first use.
// ----------------------------------------------------------------------------
module channel_usage_counter_table #(
    parameter int DOMAINS         = 256,
    parameter int GROUP_SIZE      = 16,
    parameter int PAIR_ENTRIES    = 64,
    parameter int PURPOSE_ENTRIES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        action,
    input  logic [7:0]        domain,
    input  logic [7:0]        remote_domain,
    input  logic [31:0]       purpose,
    input  logic signed [7:0] delta,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [31:0]       total_count,
    output logic              remote_found,
    output logic [31:0]       remote_count,
    output logic              purpose_found,
    output logic [7:0]        purpose_count
);

    localparam int NGROUPS   = (DOMAINS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GW        = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    // the domain field is 8 bits, so only the first 256 domains are reachable
    localparam int TOT_DEPTH = (DOMAINS < 256) ? DOMAINS : 256;
    localparam int TAW       = $clog2(TOT_DEPTH);
    localparam int PW        = $clog2(PAIR_ENTRIES);
    localparam int QW        = $clog2(PURPOSE_ENTRIES);
    localparam int MAXN      = (PAIR_ENTRIES > PURPOSE_ENTRIES) ? PAIR_ENTRIES
                                                                : PURPOSE_ENTRIES;
    localparam int SW        = $clog2(MAXN);
    localparam int GCW       = $clog2(GROUP_SIZE + 1);
    localparam int SAW       = 10;
    localparam int PEW       = $bits(cuct_pkg::pair_entry_t);
    localparam int QEW       = $bits(cuct_pkg::purp_entry_t);

    // group number and group base of every domain, fixed at elaboration
    logic [GW-1:0]  grp_lut  [256];
    logic [SAW-1:0] base_lut [256];
    for (genvar dd = 0; dd < 256; dd++)
    begin : g_lut
        assign grp_lut[dd]  = GW'(dd / GROUP_SIZE);
        assign base_lut[dd] = SAW'((dd / GROUP_SIZE) * GROUP_SIZE);
    end

    // sequencer state
    cuct_pkg::state_t state_reg, state_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [GCW-1:0]   sweep_reg, sweep_next;
    logic             grp_en_reg [NGROUPS];
    logic             grp_set;

    // latched command word
    logic [1:0]        act_reg;
    logic [7:0]        dom_reg;
    logic [7:0]        rem_reg;
    logic [31:0]       key_reg;
    logic signed [7:0] delta_reg;

    // search results
    logic          pm_reg, pm_next;
    logic [PW-1:0] pidx_reg, pidx_next;
    logic [31:0]   ptally_reg, ptally_next;
    logic          pf_reg, pf_next;
    logic [PW-1:0] pfidx_reg, pfidx_next;
    logic          qm_reg, qm_next;
    logic [QW-1:0] qidx_reg, qidx_next;
    logic [7:0]    qtally_reg, qtally_next;
    logic          qf_reg, qf_next;
    logic [QW-1:0] qfidx_reg, qfidx_next;
    logic [31:0]   total_reg, total_next;

    // finished result, then output register
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_total_reg, res_total_next;
    logic        res_rf_reg, res_rf_next;
    logic [31:0] res_rc_reg, res_rc_next;
    logic        res_qf_reg, res_qf_next;
    logic [7:0]  res_qc_reg, res_qc_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_status_reg;
    logic [31:0] out_total_reg;
    logic        out_rf_reg;
    logic [31:0] out_rc_reg;
    logic        out_qf_reg;
    logic [7:0]  out_qc_reg;
    logic        out_load;

    // decode of the latched command
    logic          in_range;
    logic          enabled;
    logic [GW-1:0] grp;
    logic [SAW-1:0] sweep_addr;
    logic          search_last;
    logic [31:0]   dext;

    // total memory
    logic           ram_we;
    logic [TAW-1:0] ram_waddr;
    logic [31:0]    ram_wdata;
    logic           ram_re;
    logic [31:0]    ram_rdata;

    // rings
    cuct_pkg::ring_ctl_t   pair_ctl;
    cuct_pkg::ring_ctl_t   purp_ctl;
    logic [PW-1:0]         pair_widx;
    logic [QW-1:0]         purp_widx;
    cuct_pkg::pair_entry_t pair_wentry;
    cuct_pkg::purp_entry_t purp_wentry;
    logic                  pair_tv;
    logic [PEW-1:0]        pair_td;
    logic                  purp_tv;
    logic [QEW-1:0]        purp_td;
    cuct_pkg::pair_entry_t pair_tail;
    cuct_pkg::purp_entry_t purp_tail;
    logic                  pair_active;
    logic                  purp_active;
    logic [PW-1:0]         pair_pos;
    logic [QW-1:0]         purp_pos;

    // update arithmetic
    logic        p_ok;
    logic        q_ok;
    logic [31:0] p_new;
    logic [7:0]  q_new;

    assign in_range    = (32'(dom_reg) < DOMAINS);
    assign grp         = grp_lut[dom_reg];
    assign enabled     = in_range && grp_en_reg[grp];
    assign sweep_addr  = base_lut[dom_reg] + SAW'(sweep_reg);
    assign search_last = (step_reg == SW'(MAXN - 1));
    assign dext        = {{24{delta_reg[7]}}, delta_reg};

    assign pair_tail   = cuct_pkg::pair_entry_t'(pair_td);
    assign purp_tail   = cuct_pkg::purp_entry_t'(purp_td);
    assign pair_active = (state_reg == cuct_pkg::ST_SEARCH)
                         && (32'(step_reg) < PAIR_ENTRIES);
    assign purp_active = (state_reg == cuct_pkg::ST_SEARCH)
                         && (32'(step_reg) < PURPOSE_ENTRIES);
    // the tail holds entries in descending index order during a rotation
    assign pair_pos    = PW'(PAIR_ENTRIES - 1 - int'(step_reg));
    assign purp_pos    = QW'(PURPOSE_ENTRIES - 1 - int'(step_reg));

    // new counts for an update: existing entry or a fresh one from zero
    assign p_ok  = pm_reg || pf_reg;
    assign q_ok  = p_ok && (qm_reg || qf_reg);
    assign p_new = (pm_reg ? ptally_reg : 32'd0) + dext;
    assign q_new = (qm_reg ? qtally_reg : 8'd0) + delta_reg;

    assign in_ready = (state_reg == cuct_pkg::ST_IDLE);
    assign out_load = (state_reg == cuct_pkg::ST_DONE) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cuct_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cuct_pkg::ST_DISPATCH;
                end
            end
            cuct_pkg::ST_DISPATCH:
            begin
                priority if (!in_range)
                begin
                    state_next = cuct_pkg::ST_DONE;
                end
                else if (act_reg == cuct_pkg::ACT_CREATE)
                begin
                    state_next = enabled ? cuct_pkg::ST_RDCAP : cuct_pkg::ST_SWEEP;
                end
                else if (!enabled)
                begin
                    state_next = cuct_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cuct_pkg::ST_SEARCH;
                end
            end
            cuct_pkg::ST_SWEEP:
            begin
                if (sweep_reg == GCW'(GROUP_SIZE - 1))
                begin
                    state_next = cuct_pkg::ST_DONE;
                end
            end
            cuct_pkg::ST_RDCAP:
            begin
                state_next = cuct_pkg::ST_DONE;
            end
            cuct_pkg::ST_SEARCH:
            begin
                if (search_last)
                begin
                    state_next = cuct_pkg::ST_APPLY;
                end
            end
            cuct_pkg::ST_APPLY:
            begin
                state_next = cuct_pkg::ST_DONE;
            end
            cuct_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = cuct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cuct_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and control outputs
    always_comb
    begin
        step_next       = step_reg;
        sweep_next      = sweep_reg;
        grp_set         = 1'b0;
        pm_next         = pm_reg;
        pidx_next       = pidx_reg;
        ptally_next     = ptally_reg;
        pf_next         = pf_reg;
        pfidx_next      = pfidx_reg;
        qm_next         = qm_reg;
        qidx_next       = qidx_reg;
        qtally_next     = qtally_reg;
        qf_next         = qf_reg;
        qfidx_next      = qfidx_reg;
        total_next      = total_reg;
        res_status_next = res_status_reg;
        res_total_next  = res_total_reg;
        res_rf_next     = res_rf_reg;
        res_rc_next     = res_rc_reg;
        res_qf_next     = res_qf_reg;
        res_qc_next     = res_qc_reg;
        ram_we          = 1'b0;
        ram_waddr       = dom_reg[TAW-1:0];
        ram_wdata       = 32'd0;
        ram_re          = 1'b0;
        pair_ctl        = '0;
        purp_ctl        = '0;
        pair_widx       = pidx_reg;
        purp_widx       = qidx_reg;
        pair_wentry     = '{owner: dom_reg, remote: rem_reg, tally: p_new};
        purp_wentry     = '{owner: dom_reg, remote: rem_reg, key: key_reg,
                            tally: q_new};

        unique case (state_reg)
            cuct_pkg::ST_DISPATCH:
            begin
                step_next       = '0;
                sweep_next      = '0;
                pm_next         = 1'b0;
                pf_next         = 1'b0;
                qm_next         = 1'b0;
                qf_next         = 1'b0;
                res_status_next = cuct_pkg::STAT_OK;
                res_total_next  = 32'd0;
                res_rf_next     = 1'b0;
                res_rc_next     = 32'd0;
                res_qf_next     = 1'b0;
                res_qc_next     = 8'd0;
                priority if (!in_range)
                begin
                    res_status_next = cuct_pkg::STAT_NO_GROUP;
                end
                else if (act_reg == cuct_pkg::ACT_CREATE)
                begin
                    grp_set = !enabled;
                    ram_re  = enabled;
                end
                else if (!enabled)
                begin
                    res_status_next = cuct_pkg::STAT_NO_GROUP;
                end
                else if (act_reg == cuct_pkg::ACT_DESTROY)
                begin
                    ram_we = 1'b1;
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            cuct_pkg::ST_SWEEP:
            begin
                // zero the new group's totals, one domain per cycle
                ram_we     = (sweep_addr < SAW'(TOT_DEPTH));
                ram_waddr  = sweep_addr[TAW-1:0];
                sweep_next = sweep_reg + GCW'(1);
            end
            cuct_pkg::ST_RDCAP:
            begin
                res_total_next = ram_rdata;
            end
            cuct_pkg::ST_SEARCH:
            begin
                step_next = search_last ? '0 : step_reg + SW'(1);
                if (step_reg == '0)
                begin
                    total_next = ram_rdata;
                end
                pair_ctl.rotate = pair_active;
                purp_ctl.rotate = purp_active;
                if (act_reg == cuct_pkg::ACT_DESTROY)
                begin
                    pair_ctl.kill = pair_active && (pair_tail.owner == dom_reg);
                    purp_ctl.kill = purp_active && (purp_tail.owner == dom_reg);
                end
                if (pair_active)
                begin
                    if (pair_tv && pair_tail.owner == dom_reg
                        && pair_tail.remote == rem_reg)
                    begin
                        pm_next     = 1'b1;
                        pidx_next   = pair_pos;
                        ptally_next = pair_tail.tally;
                    end
                    // last free one seen is the lowest index
                    if (!pair_tv)
                    begin
                        pf_next    = 1'b1;
                        pfidx_next = pair_pos;
                    end
                end
                if (purp_active)
                begin
                    if (purp_tv && purp_tail.owner == dom_reg
                        && purp_tail.remote == rem_reg && purp_tail.key == key_reg)
                    begin
                        qm_next     = 1'b1;
                        qidx_next   = purp_pos;
                        qtally_next = purp_tail.tally;
                    end
                    if (!purp_tv)
                    begin
                        qf_next    = 1'b1;
                        qfidx_next = purp_pos;
                    end
                end
            end
            cuct_pkg::ST_APPLY:
            begin
                unique case (act_reg)
                    cuct_pkg::ACT_QUERY:
                    begin
                        res_total_next = total_reg;
                        res_rf_next    = pm_reg;
                        res_rc_next    = pm_reg ? ptally_reg : 32'd0;
                        res_qf_next    = pm_reg && qm_reg;
                        res_qc_next    = (pm_reg && qm_reg) ? qtally_reg : 8'd0;
                    end
                    cuct_pkg::ACT_UPDATE:
                    begin
                        ram_we             = 1'b1;
                        ram_wdata          = total_reg + dext;
                        res_total_next     = total_reg + dext;
                        pair_ctl.wr_en     = p_ok;
                        pair_ctl.wr_valid  = 1'b1;
                        pair_widx          = pm_reg ? pidx_reg : pfidx_reg;
                        purp_ctl.wr_en     = q_ok;
                        purp_ctl.wr_valid  = 1'b1;
                        purp_widx          = qm_reg ? qidx_reg : qfidx_reg;
                        res_rf_next        = p_ok;
                        res_rc_next        = p_ok ? p_new : 32'd0;
                        res_qf_next        = q_ok;
                        res_qc_next        = q_ok ? q_new : 8'd0;
                        priority if (!p_ok)
                        begin
                            res_status_next = cuct_pkg::STAT_PAIR_FULL;
                        end
                        else if (!q_ok)
                        begin
                            res_status_next = cuct_pkg::STAT_PURP_FULL;
                        end
                        else
                        begin
                            res_status_next = cuct_pkg::STAT_OK;
                        end
                    end
                    default:
                    begin
                        // destroy: all result fields stay zero
                        res_total_next = 32'd0;
                    end
                endcase
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cuct_pkg::ST_IDLE;
            step_reg      <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int g = 0; g < NGROUPS; g++)
            begin
                grp_en_reg[g] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
            if (grp_set)
            begin
                grp_en_reg[grp] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg   <= action;
            dom_reg   <= domain;
            rem_reg   <= remote_domain;
            key_reg   <= purpose;
            delta_reg <= delta;
        end
        pm_reg         <= pm_next;
        pidx_reg       <= pidx_next;
        ptally_reg     <= ptally_next;
        pf_reg         <= pf_next;
        pfidx_reg      <= pfidx_next;
        qm_reg         <= qm_next;
        qidx_reg       <= qidx_next;
        qtally_reg     <= qtally_next;
        qf_reg         <= qf_next;
        qfidx_reg      <= qfidx_next;
        total_reg      <= total_next;
        res_status_reg <= res_status_next;
        res_total_reg  <= res_total_next;
        res_rf_reg     <= res_rf_next;
        res_rc_reg     <= res_rc_next;
        res_qf_reg     <= res_qf_next;
        res_qc_reg     <= res_qc_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_total_reg  <= res_total_reg;
            out_rf_reg     <= res_rf_reg;
            out_rc_reg     <= res_rc_reg;
            out_qf_reg     <= res_qf_reg;
            out_qc_reg     <= res_qc_reg;
        end
    end

    // domain totals
    cuct_ram #(.WIDTH(32), .DEPTH(TOT_DEPTH)) u_total_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (dom_reg[TAW-1:0]),
        .rdata (ram_rdata)
    );

    // (domain, remote) pair table
    cuct_ring #(.N(PAIR_ENTRIES), .W(PEW)) u_pair_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (pair_ctl),
        .wr_idx     (pair_widx),
        .wr_data    (PEW'(pair_wentry)),
        .tail_valid (pair_tv),
        .tail_data  (pair_td)
    );

    // (domain, remote, purpose) table
    cuct_ring #(.N(PURPOSE_ENTRIES), .W(QEW)) u_purp_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (purp_ctl),
        .wr_idx     (purp_widx),
        .wr_data    (QEW'(purp_wentry)),
        .tail_valid (purp_tv),
        .tail_data  (purp_td)
    );

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign total_count   = out_total_reg;
    assign remote_found  = out_rf_reg;
    assign remote_count  = out_rc_reg;
    assign purpose_found = out_qf_reg;
    assign purpose_count = out_qc_reg;

endmodule

>>> sv/cuct_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module cuct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cuct_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuct_cell
// one table entry of a ring: takes its neighbor's entry on shift
// ----------------------------------------------------------------------------
module cuct_cell #(
    parameter int W = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cuct_pkg::cell_ctl_t ctl,
    input  logic                prev_valid,
    input  logic [W-1:0]        prev_data,
    input  logic                wr_valid,
    input  logic [W-1:0]        wr_data,
    output logic                valid,
    output logic [W-1:0]        data
);

    logic         valid_reg;
    logic         valid_next;
    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        priority if (ctl.wr_en)
        begin
            valid_next = wr_valid;
            data_next  = wr_data;
        end
        else if (ctl.shift)
        begin
            valid_next = prev_valid;
            data_next  = prev_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> sv/cuct_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuct_ring
// associative table as a ring of cells; the tail entry is seen each cycle
// ----------------------------------------------------------------------------
module cuct_ring #(
    parameter int N = 64,
    parameter int W = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cuct_pkg::ring_ctl_t  ctl,
    input  logic [$clog2(N)-1:0] wr_idx,
    input  logic [W-1:0]         wr_data,
    output logic                 tail_valid,
    output logic [W-1:0]         tail_data
);

    logic         v [N];
    logic [W-1:0] d [N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        cuct_pkg::cell_ctl_t cctl;
        logic                pv;
        logic [W-1:0]        pd;

        assign cctl.shift = ctl.rotate;
        assign cctl.wr_en = ctl.wr_en && (wr_idx == ($clog2(N))'(i));

        if (i == 0)
        begin : g_head
            // wrap link; entries being torn down drop out here
            assign pv = v[N-1] & ~ctl.kill;
            assign pd = d[N-1];
        end
        else
        begin : g_body
            assign pv = v[i-1];
            assign pd = d[i-1];
        end

        cuct_cell #(.W(W)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (cctl),
            .prev_valid (pv),
            .prev_data  (pd),
            .wr_valid   (ctl.wr_valid),
            .wr_data    (wr_data),
            .valid      (v[i]),
            .data       (d[i])
        );
    end

    assign tail_valid = v[N-1];
    assign tail_data  = d[N-1];

endmodule

>>> sv/cuct_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuct_checker
// port-level checks of the channel usage counter table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cuct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [31:0] total_count,
    input logic        remote_found,
    input logic [31:0] remote_count,
    input logic        purpose_found,
    input logic [7:0]  purpose_count
);

    // one command word in flight at a time
    `CUCT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

    // a stalled result word holds
    `CUCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(total_count) && $stable(status))

    // a rejected command reports nothing else
    `CUCT_ASSERT_IMPL(a_nogroup_zero, out_valid && status == cuct_pkg::STAT_NO_GROUP,
        total_count == 32'd0 && !remote_found && !purpose_found)

    // a purpose entry is only reported under a found pair
    `CUCT_ASSERT_IMPL(a_purpose_needs_pair, out_valid && !remote_found,
        !purpose_found && remote_count == 32'd0 && purpose_count == 8'd0)

endmodule

bind channel_usage_counter_table cuct_checker u_cuct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .total_count   (total_count),
    .remote_found  (remote_found),
    .remote_count  (remote_count),
    .purpose_found (purpose_found),
    .purpose_count (purpose_count)
);

>>> test/channel_usage_counter_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// channel_usage_counter_table_tb
// self-checking bench for the channel usage counter table
// ----------------------------------------------------------------------------
// a queue of command words is built up front: a directed opening, then random
// commands over a small pool of domains, remotes and purpose keys so that
// entries are hit again, tables fill up and destroys free them. a driver feeds
// the words with random idle bursts, a monitor stalls the result side at
// random, and a table model predicts each result when its command is taken.
// ----------------------------------------------------------------------------
module channel_usage_counter_table_tb;

    localparam int NUM_GROUPS   = 16;
    localparam int GRP_SIZE     = 16;
    localparam int NUM_PAIRS    = 64;
    localparam int NUM_PURPOSES = 128;
    localparam int RANDOM_WORDS = 1800;
    localparam int CALM_TAIL    = 150;
    localparam int STUCK_LIMIT  = 3000;

    typedef struct {
        logic [1:0]        action;
        logic [7:0]        domain;
        logic [7:0]        remote;
        logic [31:0]       key;
        logic signed [7:0] delta;
    } command_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] total;
        logic        rfound;
        logic [31:0] rcount;
        logic        pfound;
        logic [7:0]  pcount;
    } counts_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = cuct_pkg::ACT_QUERY;
    logic [7:0]        domain = '0;
    logic [7:0]        remote_domain = '0;
    logic [31:0]       purpose = '0;
    logic signed [7:0] delta = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        status;
    logic [31:0]       total_count;
    logic              remote_found;
    logic [31:0]       remote_count;
    logic              purpose_found;
    logic [7:0]        purpose_count;

    command_t pending_cmds[$];
    counts_t  expected_counts[$];
    int       total_words;
    int       words_sent = 0;
    int       in_gap = 0;
    int       out_gap = 0;
    int       stuck_cycles = 0;
    bit       in_took = 1'b0;
    bit       failed = 1'b0;

    // model of the three table levels
    bit          grp_on[NUM_GROUPS];
    logic [31:0] dom_sum[256];
    bit          pr_used[NUM_PAIRS];
    logic [7:0]  pr_dom[NUM_PAIRS];
    logic [7:0]  pr_rem[NUM_PAIRS];
    logic [31:0] pr_cnt[NUM_PAIRS];
    bit          pu_used[NUM_PURPOSES];
    logic [7:0]  pu_dom[NUM_PURPOSES];
    logic [7:0]  pu_rem[NUM_PURPOSES];
    logic [31:0] pu_key[NUM_PURPOSES];
    logic [7:0]  pu_cnt[NUM_PURPOSES];

    channel_usage_counter_table DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .domain(domain), .remote_domain(remote_domain),
        .purpose(purpose), .delta(delta),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .total_count(total_count),
        .remote_found(remote_found), .remote_count(remote_count),
        .purpose_found(purpose_found), .purpose_count(purpose_count)
    );

    always #2 clk = ~clk;

    function automatic int find_pair_slot(logic [7:0] d, logic [7:0] r);
        for (int i = 0; i < NUM_PAIRS; i++)
            if (pr_used[i] && pr_dom[i] == d && pr_rem[i] == r)
                return i;
        return -1;
    endfunction

    function automatic int find_purpose_slot(logic [7:0] d, logic [7:0] r, logic [31:0] k);
        for (int i = 0; i < NUM_PURPOSES; i++)
            if (pu_used[i] && pu_dom[i] == d && pu_rem[i] == r && pu_key[i] == k)
                return i;
        return -1;
    endfunction

    // apply one command to the table model and return the counts it reports
    function automatic counts_t apply_command(command_t c);
        counts_t     res;
        int          grp;
        int          p;
        int          q;
        logic [31:0] wide;
        res = '{cuct_pkg::STAT_OK, 32'd0, 1'b0, 32'd0, 1'b0, 8'd0};
        grp = c.domain / GRP_SIZE;
        wide = {{24{c.delta[7]}}, c.delta};
        if (c.action == cuct_pkg::ACT_CREATE)
        begin
            if (!grp_on[grp])
            begin
                grp_on[grp] = 1'b1;
                for (int d = grp * GRP_SIZE; d < (grp + 1) * GRP_SIZE; d++)
                    dom_sum[d] = '0;
            end
            res.total = dom_sum[c.domain];
        end
        else if (!grp_on[grp])
        begin
            res.status = cuct_pkg::STAT_NO_GROUP;
        end
        else if (c.action == cuct_pkg::ACT_DESTROY)
        begin
            dom_sum[c.domain] = '0;
            for (int i = 0; i < NUM_PAIRS; i++)
                if (pr_used[i] && pr_dom[i] == c.domain)
                    pr_used[i] = 1'b0;
            for (int i = 0; i < NUM_PURPOSES; i++)
                if (pu_used[i] && pu_dom[i] == c.domain)
                    pu_used[i] = 1'b0;
        end
        else if (c.action == cuct_pkg::ACT_UPDATE)
        begin
            dom_sum[c.domain] += wide;
            res.total = dom_sum[c.domain];
            p = find_pair_slot(c.domain, c.remote);
            for (int i = 0; i < NUM_PAIRS && p < 0; i++)
                if (!pr_used[i])
                begin
                    p = i;
                    pr_used[i] = 1'b1;
                    pr_dom[i] = c.domain;
                    pr_rem[i] = c.remote;
                    pr_cnt[i] = '0;
                end
            if (p < 0)
            begin
                res.status = cuct_pkg::STAT_PAIR_FULL;
            end
            else
            begin
                pr_cnt[p] += wide;
                res.rfound = 1'b1;
                res.rcount = pr_cnt[p];
                q = find_purpose_slot(c.domain, c.remote, c.key);
                for (int i = 0; i < NUM_PURPOSES && q < 0; i++)
                    if (!pu_used[i])
                    begin
                        q = i;
                        pu_used[i] = 1'b1;
                        pu_dom[i] = c.domain;
                        pu_rem[i] = c.remote;
                        pu_key[i] = c.key;
                        pu_cnt[i] = '0;
                    end
                if (q < 0)
                begin
                    res.status = cuct_pkg::STAT_PURP_FULL;
                end
                else
                begin
                    pu_cnt[q] += c.delta;
                    res.pfound = 1'b1;
                    res.pcount = pu_cnt[q];
                end
            end
        end
        else
        begin
            res.total = dom_sum[c.domain];
            p = find_pair_slot(c.domain, c.remote);
            if (p >= 0)
            begin
                res.rfound = 1'b1;
                res.rcount = pr_cnt[p];
                q = find_purpose_slot(c.domain, c.remote, c.key);
                if (q >= 0)
                begin
                    res.pfound = 1'b1;
                    res.pcount = pu_cnt[q];
                end
            end
        end
        return res;
    endfunction

    task automatic add_cmd(logic [1:0] a, logic [7:0] d, logic [7:0] r,
                           logic [31:0] k, logic signed [7:0] dl);
        command_t c;
        c = '{a, d, r, k, dl};
        pending_cmds.push_back(c);
    endtask

    // command list: directed opening, then random traffic
    initial
    begin
        logic [1:0]  a;
        logic [7:0]  d;
        logic [7:0]  r;
        logic [31:0] k;
        logic [7:0]  dl;
        int          pick;
        // commands on a group that was never created
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd3,   8'd1,   32'd1,         8'sd1);
        add_cmd(cuct_pkg::ACT_DESTROY, 8'd200, 8'd0,   32'd0,         8'sd0);
        // new group, then create again on an enabled group
        add_cmd(cuct_pkg::ACT_CREATE,  8'd3,   8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd3,   8'd0,   32'd0,         8'sd127);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd3,   8'd0,   32'd0,         -8'sd128);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd3,   8'd255, 32'hFFFF_FFFF, 8'sd127);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd3,   8'd255, 32'hFFFF_FFFF, 8'sd127);
        add_cmd(cuct_pkg::ACT_CREATE,  8'd5,   8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd255, 32'hFFFF_FFFF, 8'sd0);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd255, 32'h5555_AAAA, 8'sd0);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd7,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_DESTROY, 8'd3,   8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd3,   8'd255, 32'hFFFF_FFFF, 8'sd0);
        add_cmd(cuct_pkg::ACT_CREATE,  8'd255, 8'd0,   32'd0,         8'sd0);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd255, 8'd255, 32'hAAAA_5555, -8'sd1);
        add_cmd(cuct_pkg::ACT_UPDATE,  8'd255, 8'd254, 32'h5555_AAAA, 8'sd1);
        add_cmd(cuct_pkg::ACT_QUERY,   8'd255, 8'd255, 32'hAAAA_5555, 8'sd0);
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            pick = $urandom_range(0, 99);
            a = pick < 4 ? cuct_pkg::ACT_CREATE : pick < 9 ? cuct_pkg::ACT_DESTROY :
                pick < 70 ? cuct_pkg::ACT_UPDATE : cuct_pkg::ACT_QUERY;
            d = $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 47)) : 8'($urandom);
            r = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
            case ($urandom_range(0, 3))
                0: k = 32'($urandom_range(0, 3));
                1: k = 32'hFFFF_FFFF - 32'($urandom_range(0, 1));
                default: k = $urandom;
            endcase
            dl = $urandom_range(0, 9) < 7 ? ($urandom_range(0, 1) ? 8'h01 : 8'hFF)
                                          : 8'($urandom);
            add_cmd(a, d, r, k, dl);
        end
        total_words = pending_cmds.size();
    end

    // reset and end of run
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && !in_valid && expected_counts.size() == 0);
        repeat (200) @(posedge clk);
        if (!failed && expected_counts.size() == 0)
            $display("channel_usage_counter_table verification clean");
        else
            $display("channel_usage_counter_table verification failed");
        $finish;
    end

    // command driver, changes on the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (words_sent < total_words - CALM_TAIL && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                in_gap <= $urandom_range(0, 12);
            end
            else if (pending_cmds.size() > 0)
            begin
                command_t c;
                c = pending_cmds.pop_front();
                words_sent <= words_sent + 1;
                in_valid <= 1'b1;
                action <= c.action;
                domain <= c.domain;
                remote_domain <= c.remote;
                purpose <= c.key;
                delta <= c.delta;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result side stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap <= out_gap - 1;
            end
            else if (words_sent < total_words - CALM_TAIL && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                out_gap <= $urandom_range(0, 12);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // predict on acceptance, check each result word against the oldest one
    always @(posedge clk)
    begin
        command_t c;
        counts_t  e;
        in_took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            c = '{action, domain, remote_domain, purpose, delta};
            expected_counts.push_back(apply_command(c));
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: result word with none expected, status %0d", $time, status);
                failed = 1'b1;
            end
            else
            begin
                e = expected_counts.pop_front();
                if (status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status, status);
                    failed = 1'b1;
                end
                if (total_count !== e.total)
                begin
                    $display("%0t: total_count exp %h got %h", $time, e.total, total_count);
                    failed = 1'b1;
                end
                if (remote_found !== e.rfound)
                begin
                    $display("%0t: remote_found exp %b got %b", $time, e.rfound, remote_found);
                    failed = 1'b1;
                end
                if (remote_count !== e.rcount)
                begin
                    $display("%0t: remote_count exp %h got %h", $time, e.rcount, remote_count);
                    failed = 1'b1;
                end
                if (purpose_found !== e.pfound)
                begin
                    $display("%0t: purpose_found exp %b got %b", $time, e.pfound,
                             purpose_found);
                    failed = 1'b1;
                end
                if (purpose_count !== e.pcount)
                begin
                    $display("%0t: purpose_count exp %h got %h", $time, e.pcount,
                             purpose_count);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("channel_usage_counter_table verification failed");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
